FILE: rtl/core/sensor_bus_transmitter_macros.svh
// ----------------------------------------------------------------------------
// Sensor bus transmitter assertion macros
// Concurrent assertion wrappers clocked on clk, compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef SENSOR_BUS_TRANSMITTER_MACROS_SVH
`define SENSOR_BUS_TRANSMITTER_MACROS_SVH

`ifndef NO_ASSERTIONS
// check while out of reset
`define SBT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// check at every edge, reset included
`define SBT_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SBT_ASSERT(lbl, prop, msg)
`define SBT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: rtl/core/sbt_pkg.sv
// ----------------------------------------------------------------------------
// Sensor bus transmitter package
// Item and result types, action and status codes, register map, phase codes.
// ----------------------------------------------------------------------------
package sbt_pkg;

	typedef logic [1:0] action_t;
	localparam action_t ACT_TICK  = 2'd0;
	localparam action_t ACT_PUSH  = 2'd1;
	localparam action_t ACT_START = 2'd2;

	typedef logic [1:0] status_t;
	localparam status_t ST_NONE      = 2'd0;
	localparam status_t ST_SENT      = 2'd1;
	localparam status_t ST_BUS_BUSY  = 2'd2;
	localparam status_t ST_NO_STROBE = 2'd3;

	typedef logic [2:0] reg_idx_t;
	localparam reg_idx_t REG_IDLE_TIMEOUT   = 3'd0;
	localparam reg_idx_t REG_IDLE_RETRIES   = 3'd1;
	localparam reg_idx_t REG_STROBE_TIMEOUT = 3'd2;
	localparam reg_idx_t REG_STROBE_RETRIES = 3'd3;
	localparam reg_idx_t REG_START_PAUSE    = 3'd4;
	localparam reg_idx_t REG_BIT_PAUSE      = 3'd5;
	localparam reg_idx_t REG_BYTE_PAUSE     = 3'd6;

	localparam logic [15:0] RST_IDLE_TIMEOUT   = 16'd20000;
	localparam logic [7:0]  RST_IDLE_RETRIES   = 8'd10;
	localparam logic [15:0] RST_STROBE_TIMEOUT = 16'hFFFF;
	localparam logic [7:0]  RST_STROBE_RETRIES = 8'd255;
	localparam logic [15:0] RST_START_PAUSE    = 16'd100;
	localparam logic [15:0] RST_BIT_PAUSE      = 16'd20;
	localparam logic [15:0] RST_BYTE_PAUSE     = 16'd50;

	typedef enum logic [6:0] {
		PH_IDLE     = 7'b0000001,
		PH_WAIT_ACT = 7'b0000010,
		PH_WAIT_CLK = 7'b0000100,
		PH_START    = 7'b0001000,
		PH_BIT_HI   = 7'b0010000,
		PH_BIT_LO   = 7'b0100000,
		PH_GAP      = 7'b1000000
	} phase_t;

	typedef struct packed {
		action_t     action;
		logic [7:0]  push_byte;
		logic        act_sample;
		logic        clk_sample;
	} item_t;

	typedef struct packed {
		logic    dat_level;
		logic    dat_drive;
		logic    act_drive_low;
		logic    clk_level;
		logic    clk_drive;
		logic    busy_res;
		logic    finished;
		status_t status;
	} res_t;

endpackage

FILE: rtl/core/sbt_msg_store.sv
// ----------------------------------------------------------------------------
// Sensor bus transmitter message store
// Single-port-write, registered-read byte memory for the outgoing message.
// ----------------------------------------------------------------------------
module sbt_msg_store #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// hold read data between reads
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: rtl/core/sensor_bus_transmitter.sv
// ----------------------------------------------------------------------------
// Sensor bus transmitter
// Three-wire bus sender: buffers message bytes, handshakes ACT and CLK, then
// clocks bytes out LSB first with programmable pauses and timeouts.
// ----------------------------------------------------------------------------
//  channel  signals                              transfer when
//  item     item_valid, item_stall, item         item_valid & !item_stall
//  res      res_valid, res_stall, res            res_valid & !res_stall
//  cfg      cfg_valid, cfg_ready, cfg_index/data cfg_valid & cfg_ready
//
//  One item per cycle while item_stall is low; its result is presented on the following cycle.
//  The message store read port sets the latency: the byte for the new
//  position is read at the transfer edge and selected at the result.
//  item_stall rises while a result is held under res_stall.
//  Reset clears the phase, counters and the result valid and loads the
//  register defaults; the message store needs no clearing pass.
// ----------------------------------------------------------------------------
`include "sensor_bus_transmitter_macros.svh"

module sensor_bus_transmitter
	import sbt_pkg::*;
#(
	parameter int MAX_MSG_BYTES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  item_t       item,
	output logic        res_valid,
	input  logic        res_stall,
	output res_t        res,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  reg_idx_t    cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int AW = (MAX_MSG_BYTES > 1) ? $clog2(MAX_MSG_BYTES) : 1;
	localparam int CW = $clog2(MAX_MSG_BYTES + 1);
	localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_MSG_BYTES);

	logic [15:0] idle_timeout_q, strobe_timeout_q;
	logic [7:0]  idle_retries_q, strobe_retries_q;
	logic [15:0] start_pause_q, bit_pause_q, byte_pause_q;

	phase_t        phase_q, phase_d;
	logic [CW-1:0] msg_count_q, msg_count_d;
	logic [15:0]   tick_q, tick_d;
	logic [7:0]    retry_q, retry_d;
	logic [AW-1:0] byte_idx_q, byte_idx_d;
	logic [2:0]    bit_idx_q, bit_idx_d;
	status_t       status_q, status_d;
	logic          fin_d;

	logic          accept;
	logic          wr_en;
	logic [7:0]    rd_data;
	logic          res_valid_q;
	res_t          res_q, res_d;
	logic          dsel_q, dsel_d;
	logic [2:0]    bit_sel_q;

	logic [16:0]   tick_inc;
	logic [15:0]   period;
	logic [7:0]    retries;
	logic [15:0]   pause;
	logic          spent;
	logic          pause_done;

	assign accept     = item_valid && !item_stall;
	assign item_stall = res_valid_q && res_stall;
	assign cfg_ready  = 1'b1;
	assign wr_en      = accept && (item.action == ACT_PUSH) && (phase_q == PH_IDLE)
		&& (msg_count_q < MAX_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_timeout_q   <= RST_IDLE_TIMEOUT;
			idle_retries_q   <= RST_IDLE_RETRIES;
			strobe_timeout_q <= RST_STROBE_TIMEOUT;
			strobe_retries_q <= RST_STROBE_RETRIES;
			start_pause_q    <= RST_START_PAUSE;
			bit_pause_q      <= RST_BIT_PAUSE;
			byte_pause_q     <= RST_BYTE_PAUSE;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_IDLE_TIMEOUT:   idle_timeout_q   <= cfg_data;
				REG_IDLE_RETRIES:   idle_retries_q   <= cfg_data[7:0];
				REG_STROBE_TIMEOUT: strobe_timeout_q <= cfg_data;
				REG_STROBE_RETRIES: strobe_retries_q <= cfg_data[7:0];
				REG_START_PAUSE:    start_pause_q    <= cfg_data;
				REG_BIT_PAUSE:      bit_pause_q      <= cfg_data;
				REG_BYTE_PAUSE:     byte_pause_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// shared timeout and pause arithmetic
	always_comb begin
		period  = (phase_q == PH_WAIT_ACT) ? idle_timeout_q : strobe_timeout_q;
		retries = (phase_q == PH_WAIT_ACT) ? idle_retries_q : strobe_retries_q;
		case (phase_q)
			PH_START: pause = start_pause_q;
			PH_GAP:   pause = byte_pause_q;
			default:  pause = bit_pause_q;
		endcase
		tick_inc   = {1'b0, tick_q} + 17'd1;
		spent      = (tick_inc >= {1'b0, period}) && (retry_q >= retries);
		pause_done = (tick_q >= pause);
	end

	always_comb begin
		phase_d     = phase_q;
		msg_count_d = msg_count_q;
		tick_d      = tick_q;
		retry_d     = retry_q;
		byte_idx_d  = byte_idx_q;
		bit_idx_d   = bit_idx_q;
		status_d    = status_q;
		fin_d       = 1'b0;
		if (accept) begin
			case (item.action)
				ACT_PUSH: begin
					if (wr_en) begin
						msg_count_d = msg_count_q + CW'(1);
					end
				end
				ACT_START: begin
					if (phase_q == PH_IDLE) begin
						phase_d    = PH_WAIT_ACT;
						tick_d     = '0;
						retry_d    = '0;
						byte_idx_d = '0;
						bit_idx_d  = '0;
						status_d   = ST_NONE;
					end
				end
				ACT_TICK: begin
					case (phase_q)
						PH_IDLE: ;
						PH_WAIT_ACT, PH_WAIT_CLK: begin
							if ((phase_q == PH_WAIT_ACT) ? item.act_sample : !item.clk_sample) begin
								phase_d = (phase_q == PH_WAIT_ACT) ? PH_WAIT_CLK : PH_START;
								tick_d  = '0;
								retry_d = '0;
							end else if (spent) begin
								fin_d    = 1'b1;
								status_d = (phase_q == PH_WAIT_ACT) ? ST_BUS_BUSY : ST_NO_STROBE;
							end else if (tick_inc >= {1'b0, period}) begin
								tick_d  = '0;
								retry_d = retry_q + 8'd1;
							end else begin
								tick_d = tick_inc[15:0];
							end
						end
						PH_START, PH_BIT_HI, PH_BIT_LO, PH_GAP: begin
							if (!pause_done) begin
								tick_d = tick_inc[15:0];
							end else begin
								tick_d = '0;
								case (phase_q)
									PH_START: begin
										byte_idx_d = '0;
										bit_idx_d  = '0;
										if (msg_count_q == '0) begin
											fin_d    = 1'b1;
											status_d = ST_SENT;
										end else begin
											phase_d = PH_BIT_HI;
										end
									end
									PH_BIT_HI: phase_d = PH_BIT_LO;
									PH_BIT_LO: begin
										if (bit_idx_q < 3'd7) begin
											bit_idx_d = bit_idx_q + 3'd1;
											phase_d   = PH_BIT_HI;
										end else begin
											phase_d = PH_GAP;
										end
									end
									default: begin
										if (CW'(byte_idx_q) + CW'(1) < msg_count_q) begin
											byte_idx_d = byte_idx_q + AW'(1);
											bit_idx_d  = '0;
											phase_d    = PH_BIT_HI;
										end else begin
											fin_d    = 1'b1;
											status_d = ST_SENT;
										end
									end
								endcase
							end
						end
						default: phase_d = PH_IDLE;
					endcase
				end
				default: ;
			endcase
			// release lines and drop the message
			if (fin_d) begin
				phase_d     = PH_IDLE;
				msg_count_d = '0;
				byte_idx_d  = '0;
				bit_idx_d   = '0;
				tick_d      = '0;
				retry_d     = '0;
			end
		end
	end

	// result fields from the new phase; DAT data bit joins from the store read
	always_comb begin
		res_d          = '0;
		res_d.busy_res = (phase_d != PH_IDLE);
		res_d.finished = fin_d;
		res_d.status   = status_d;
		dsel_d         = phase_d inside {PH_BIT_HI, PH_BIT_LO, PH_GAP};
		case (phase_d)
			PH_WAIT_CLK: begin
				res_d.dat_drive     = 1'b1;
				res_d.act_drive_low = 1'b1;
			end
			PH_START: begin
				res_d.dat_drive     = 1'b1;
				res_d.dat_level     = 1'b1;
				res_d.act_drive_low = 1'b1;
			end
			PH_BIT_HI, PH_GAP: begin
				res_d.dat_drive     = 1'b1;
				res_d.act_drive_low = 1'b1;
				res_d.clk_drive     = 1'b1;
				res_d.clk_level     = 1'b1;
			end
			PH_BIT_LO: begin
				res_d.dat_drive     = 1'b1;
				res_d.act_drive_low = 1'b1;
				res_d.clk_drive     = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			msg_count_q <= '0;
			tick_q      <= '0;
			retry_q     <= '0;
			byte_idx_q  <= '0;
			bit_idx_q   <= '0;
			status_q    <= ST_NONE;
			res_valid_q <= 1'b0;
		end else begin
			phase_q     <= phase_d;
			msg_count_q <= msg_count_d;
			tick_q      <= tick_d;
			retry_q     <= retry_d;
			byte_idx_q  <= byte_idx_d;
			bit_idx_q   <= bit_idx_d;
			status_q    <= status_d;
			if (accept) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q     <= res_d;
			dsel_q    <= dsel_d;
			bit_sel_q <= bit_idx_d;
		end
	end

	sbt_msg_store #(
		.DEPTH (MAX_MSG_BYTES),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (msg_count_q[AW-1:0]),
		.wr_data (item.push_byte),
		.rd_en   (accept),
		.rd_addr (byte_idx_d),
		.rd_data (rd_data)
	);

	always_comb begin
		res           = res_q;
		res.dat_level = res_q.dat_level | (dsel_q & rd_data[bit_sel_q]);
	end

	assign res_valid = res_valid_q;

	`SBT_ASSERT(a_count_bound, msg_count_q <= MAX_COUNT, "message count beyond store depth")
	`SBT_ASSERT(a_fin_idle, res_valid && res.finished |-> !res.busy_res, "finish while busy")
	`SBT_ASSERT(a_idle_release, res_valid && !res.busy_res |-> !res.dat_drive && !res.act_drive_low && !res.clk_drive, "lines driven while idle")
	`SBT_ASSERT(a_busy_status, res_valid && res.busy_res |-> res.status == ST_NONE, "status set during a sequence")
	`SBT_ASSERT(a_byte_in_msg, (phase_q == PH_BIT_HI || phase_q == PH_BIT_LO || phase_q == PH_GAP) |-> CW'(byte_idx_q) < msg_count_q, "byte position past message end")

endmodule

FILE: tb/sv/tb_sensor_bus_transmitter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sensor bus transmitter testbench
// Drives message pushes, start requests and line-sample ticks through the item
// channel under random sender idling and receiver stalls. Every accepted item
// is run through a cycle-free model of the line sequencer, and each result
// transfer is compared field by field with the oldest predicted line state.
// Register settings are changed between phases while the sequencer is idle.
// ----------------------------------------------------------------------------
module tb_sensor_bus_transmitter;
	import sbt_pkg::*;

	localparam int MSG_DEPTH = 32;
	localparam int CYCLE_LIMIT = 2000000;
	localparam action_t ACT_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	item_t item = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	reg_idx_t cfg_index = REG_IDLE_TIMEOUT;
	logic [15:0] cfg_data = '0;

	sensor_bus_transmitter u_top (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	item_t pending_items[$];
	res_t expected_lines[$];
	res_t want_res;
	int sender_idle_pct = 0;
	int recv_stall_pct = 0;
	int err_count = 0;
	int cycle_count = 0;

	// line sequencer model state
	logic [15:0] cfg_idle_to = RST_IDLE_TIMEOUT;
	logic [7:0] cfg_idle_rt = RST_IDLE_RETRIES;
	logic [15:0] cfg_strobe_to = RST_STROBE_TIMEOUT;
	logic [7:0] cfg_strobe_rt = RST_STROBE_RETRIES;
	logic [15:0] cfg_start_p = RST_START_PAUSE;
	logic [15:0] cfg_bit_p = RST_BIT_PAUSE;
	logic [15:0] cfg_byte_p = RST_BYTE_PAUSE;
	logic [7:0] msg_mem [MSG_DEPTH] = '{default: 8'h00};
	int unsigned msg_cnt = 0;
	phase_t ph = PH_IDLE;
	int unsigned tick_n = 0;
	int unsigned retry_n = 0;
	int unsigned byte_pos = 0;
	int unsigned bit_pos = 0;
	status_t last_st = ST_NONE;
	bit seq_ended = 1'b0;

	function automatic bit budget_out(int unsigned period, int unsigned retries);
		tick_n++;
		if (tick_n >= period) begin
			tick_n = 0;
			if (retry_n >= retries)
				return 1'b1;
			retry_n++;
		end
		return 1'b0;
	endfunction

	function automatic bit pause_over(int unsigned p);
		if (tick_n >= p) begin
			tick_n = 0;
			return 1'b1;
		end
		tick_n++;
		return 1'b0;
	endfunction

	function automatic void close_seq(status_t st);
		ph = PH_IDLE;
		last_st = st;
		msg_cnt = 0;
		byte_pos = 0;
		bit_pos = 0;
		tick_n = 0;
		retry_n = 0;
		seq_ended = 1'b1;
	endfunction

	function automatic res_t predict_lines(item_t it);
		res_t r;
		logic data_bit;
		r = '0;
		seq_ended = 1'b0;
		case (it.action)
			ACT_PUSH: begin
				if (ph == PH_IDLE && msg_cnt < MSG_DEPTH) begin
					msg_mem[msg_cnt] = it.push_byte;
					msg_cnt++;
				end
			end
			ACT_START: begin
				if (ph == PH_IDLE) begin
					ph = PH_WAIT_ACT;
					tick_n = 0;
					retry_n = 0;
					byte_pos = 0;
					bit_pos = 0;
					last_st = ST_NONE;
				end
			end
			ACT_TICK: begin
				case (ph)
					PH_WAIT_ACT: begin
						if (it.act_sample) begin
							ph = PH_WAIT_CLK;
							tick_n = 0;
							retry_n = 0;
						end else if (budget_out(32'(cfg_idle_to), 32'(cfg_idle_rt)))
							close_seq(ST_BUS_BUSY);
					end
					PH_WAIT_CLK: begin
						if (!it.clk_sample) begin
							ph = PH_START;
							tick_n = 0;
							retry_n = 0;
						end else if (budget_out(32'(cfg_strobe_to), 32'(cfg_strobe_rt)))
							close_seq(ST_NO_STROBE);
					end
					PH_START: begin
						if (pause_over(32'(cfg_start_p))) begin
							byte_pos = 0;
							bit_pos = 0;
							if (msg_cnt == 0)
								close_seq(ST_SENT);
							else
								ph = PH_BIT_HI;
						end
					end
					PH_BIT_HI: begin
						if (pause_over(32'(cfg_bit_p)))
							ph = PH_BIT_LO;
					end
					PH_BIT_LO: begin
						if (pause_over(32'(cfg_bit_p))) begin
							if (bit_pos < 7) begin
								bit_pos++;
								ph = PH_BIT_HI;
							end else
								ph = PH_GAP;
						end
					end
					PH_GAP: begin
						if (pause_over(32'(cfg_byte_p))) begin
							if (byte_pos + 1 < msg_cnt) begin
								byte_pos++;
								bit_pos = 0;
								ph = PH_BIT_HI;
							end else
								close_seq(ST_SENT);
						end
					end
					default: ph = PH_IDLE;
				endcase
			end
			default: ;
		endcase

		data_bit = (byte_pos < MSG_DEPTH) ? msg_mem[byte_pos][bit_pos[2:0]] : 1'b0;
		case (ph)
			PH_WAIT_CLK: begin
				r.dat_drive = 1'b1;
				r.act_drive_low = 1'b1;
			end
			PH_START: begin
				r.dat_drive = 1'b1;
				r.dat_level = 1'b1;
				r.act_drive_low = 1'b1;
			end
			PH_BIT_HI, PH_GAP: begin
				r.dat_drive = 1'b1;
				r.dat_level = data_bit;
				r.act_drive_low = 1'b1;
				r.clk_drive = 1'b1;
				r.clk_level = 1'b1;
			end
			PH_BIT_LO: begin
				r.dat_drive = 1'b1;
				r.dat_level = data_bit;
				r.act_drive_low = 1'b1;
				r.clk_drive = 1'b1;
			end
			default: ;
		endcase
		r.busy_res = (ph != PH_IDLE);
		r.finished = seq_ended;
		r.status = last_st;
		return r;
	endfunction

	// item driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall)
				expected_lines.push_back(predict_lines(item));
			if (!item_valid || !item_stall) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					item <= pending_items.pop_front();
					item_valid <= 1'b1;
				end else
					item_valid <= 1'b0;
			end
			res_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	task automatic check_field(string field, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			err_count++;
		end
	endtask

	// result monitor
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (expected_lines.size() == 0) begin
				$error("result transfer with no line state expected");
				err_count++;
			end else begin
				want_res = expected_lines.pop_front();
				check_field("dat_level", want_res.dat_level, res.dat_level);
				check_field("dat_drive", want_res.dat_drive, res.dat_drive);
				check_field("act_drive_low", want_res.act_drive_low, res.act_drive_low);
				check_field("clk_level", want_res.clk_level, res.clk_level);
				check_field("clk_drive", want_res.clk_drive, res.clk_drive);
				check_field("busy_res", want_res.busy_res, res.busy_res);
				check_field("finished", want_res.finished, res.finished);
				check_field("status", want_res.status, res.status);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_sensor_bus_transmitter: FAIL");
			$finish;
		end
	end

	function automatic item_t make_item(action_t a, logic [7:0] b, logic as, logic cs);
		item_t t;
		t.action = a;
		t.push_byte = b;
		t.act_sample = as;
		t.clk_sample = cs;
		return t;
	endfunction

	function automatic logic coin();
		return $urandom_range(1) == 1;
	endfunction

	function automatic action_t stray_action();
		case ($urandom_range(2))
			0: return ACT_PUSH;
			1: return ACT_START;
			default: return ACT_UNUSED;
		endcase
	endfunction

	function automatic int wait_len(int budget);
		if (budget - 1 <= 12)
			return $urandom_range(1) ? budget - 1 : $urandom_range(budget - 1);
		return $urandom_range(12);
	endfunction

	task automatic add_tick(logic as, logic cs);
		pending_items.push_back(make_item(ACT_TICK, 8'($urandom), as, cs));
	endtask

	task automatic add_cmd(action_t a, logic [7:0] b);
		pending_items.push_back(make_item(a, b, coin(), coin()));
	endtask

	// one message: pushes, start, bus handshake and the transmit ticks
	task automatic gen_sequence(int max_n, bit rare_full, bit allow_timeout);
		int n;
		int m;
		int budget;
		int ticks;
		if (rare_full && $urandom_range(9) == 0)
			n = $urandom_range(34, 28);
		else
			n = $urandom_range(max_n, 0);
		if ($urandom_range(5) == 0)
			add_cmd($urandom_range(1) ? ACT_UNUSED : ACT_TICK, 8'($urandom));
		for (int i = 0; i < n; i++)
			add_cmd(ACT_PUSH, 8'($urandom));
		add_cmd(ACT_START, 8'($urandom));
		if ($urandom_range(7) == 0)
			add_cmd(ACT_START, 8'($urandom));

		budget = (int'(cfg_idle_rt) + 1) * (cfg_idle_to == 0 ? 1 : int'(cfg_idle_to));
		if (allow_timeout && budget <= 4000 && $urandom_range(7) == 0) begin
			repeat (budget) add_tick(1'b0, coin());
		end else begin
			repeat (wait_len(budget)) add_tick(1'b0, coin());
			add_tick(1'b1, coin());
			budget = (int'(cfg_strobe_rt) + 1) *
				(cfg_strobe_to == 0 ? 1 : int'(cfg_strobe_to));
			if (allow_timeout && budget <= 4000 && $urandom_range(7) == 0) begin
				repeat (budget) add_tick(coin(), 1'b1);
			end else begin
				repeat (wait_len(budget)) add_tick(coin(), 1'b1);
				add_tick(coin(), 1'b0);
				m = (n > MSG_DEPTH) ? MSG_DEPTH : n;
				ticks = int'(cfg_start_p) + 1 +
					m * (16 * (int'(cfg_bit_p) + 1) + int'(cfg_byte_p) + 1);
				for (int i = 0; i < ticks; i++) begin
					if ($urandom_range(24) == 0)
						add_cmd(stray_action(), 8'($urandom));
					add_tick(coin(), coin());
				end
			end
		end
		repeat ($urandom_range(2)) add_tick(coin(), coin());
	endtask

	task automatic run_random(int quota, int max_n, bit rare_full, bit allow_timeout);
		int base;
		base = pending_items.size();
		while (pending_items.size() - base < quota)
			gen_sequence(max_n, rare_full, allow_timeout);
	endtask

	// drain all transfers, then tick until the sequencer is idle
	task automatic settle();
		do begin
			while (pending_items.size() != 0 || item_valid || expected_lines.size() != 0)
				@(posedge clk);
			if (ph != PH_IDLE)
				add_tick(1'b1, 1'b0);
		end while (ph != PH_IDLE);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [15:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_IDLE_TIMEOUT: cfg_idle_to = val;
			REG_IDLE_RETRIES: cfg_idle_rt = val[7:0];
			REG_STROBE_TIMEOUT: cfg_strobe_to = val;
			REG_STROBE_RETRIES: cfg_strobe_rt = val[7:0];
			REG_START_PAUSE: cfg_start_p = val;
			REG_BIT_PAUSE: cfg_bit_p = val;
			REG_BYTE_PAUSE: cfg_byte_p = val;
			default: ;
		endcase
	endtask

	task automatic apply_setting(logic [15:0] idle_to, logic [15:0] idle_rt,
		logic [15:0] strobe_to, logic [15:0] strobe_rt, logic [15:0] start_p,
		logic [15:0] bit_p, logic [15:0] byte_p);
		write_reg(REG_IDLE_TIMEOUT, idle_to);
		write_reg(REG_IDLE_RETRIES, idle_rt);
		write_reg(REG_STROBE_TIMEOUT, strobe_to);
		write_reg(REG_STROBE_RETRIES, strobe_rt);
		write_reg(REG_START_PAUSE, start_p);
		write_reg(REG_BIT_PAUSE, bit_p);
		write_reg(REG_BYTE_PAUSE, byte_p);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		sender_idle_pct = 22;
		recv_stall_pct = 87;
		apply_setting(16'd1, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0);

		pending_items.push_back(make_item(ACT_UNUSED, 8'hFF, 1'b1, 1'b1));
		add_tick(1'b0, 1'b0);
		// bus never idle
		add_cmd(ACT_START, 8'h00);
		add_tick(1'b0, 1'b1);
		// no clock strobe
		add_cmd(ACT_START, 8'h00);
		add_tick(1'b1, 1'b1);
		add_tick(1'b1, 1'b1);
		// empty store
		add_cmd(ACT_START, 8'h00);
		add_tick(1'b1, 1'b0);
		add_tick(1'b1, 1'b0);
		add_tick(1'b0, 1'b1);
		// one byte, push and start while busy
		add_cmd(ACT_PUSH, 8'hFF);
		add_cmd(ACT_START, 8'h00);
		add_cmd(ACT_PUSH, 8'h00);
		add_cmd(ACT_START, 8'hFF);
		add_tick(1'b1, 1'b0);
		add_tick(1'b1, 1'b0);
		repeat (18) add_tick(coin(), coin());

		run_random(100, 4, 1'b1, 1'b1);
		settle();

		// zero timeout periods
		apply_setting(16'd0, 16'd3, 16'd0, 16'd2, 16'd1, 16'd2, 16'd1);
		run_random(100, 4, 1'b1, 1'b1);
		settle();

		sender_idle_pct = 87;
		recv_stall_pct = 22;
		for (int s = 0; s < 3; s++) begin
			if (s == 2) begin
				sender_idle_pct = 0;
				recv_stall_pct = 0;
			end
			apply_setting(16'($urandom_range(6)), 16'($urandom_range(3)),
				16'($urandom_range(6)), 16'($urandom_range(3)), 16'($urandom_range(4)),
				16'($urandom_range(3)), 16'($urandom_range(3)));
			run_random(100, 4, 1'b1, 1'b1);
			settle();
		end

		apply_setting(RST_IDLE_TIMEOUT, 16'(RST_IDLE_RETRIES), RST_STROBE_TIMEOUT,
			16'(RST_STROBE_RETRIES), RST_START_PAUSE, RST_BIT_PAUSE, RST_BYTE_PAUSE);
		run_random(100, 0, 1'b0, 1'b0);
		settle();

		apply_setting(16'hFFFF, 16'h00FF, 16'hFFFF, 16'h00FF, 16'd3, 16'd1, 16'd2);
		run_random(50, 4, 1'b0, 1'b0);
		settle();

		repeat (4) @(posedge clk);
		if (err_count == 0)
			$display("tb_sensor_bus_transmitter: PASS");
		else
			$display("tb_sensor_bus_transmitter: FAIL");
		$finish;
	end

endmodule
